// ===== hw/rtl/efp_pkg.sv =====
// ----------------------------------------------------------------------------
// efp_pkg: shared types and constants of the escape-time fractal pixel engine
// Holds the Q4.28 mapping constants, the queue item and configuration types,
// the register index codes and the small arithmetic helper functions.
// ----------------------------------------------------------------------------
package efp_pkg;

  localparam int unsigned IMG_WIDTH       = 1024;
  localparam int unsigned IMG_HEIGHT      = 1024;
  localparam int unsigned LINE_BYTES      = 4096;
  localparam int unsigned BYTES_PER_PIXEL = 4;

  localparam int unsigned COORD_W = 10;
  localparam int unsigned OFFS_W  = 22;
  localparam int unsigned COLOR_W = 24;
  localparam int unsigned ITER_W  = 13;
  localparam int unsigned Q_W     = 32;
  localparam int unsigned FRAC    = 28;
  localparam int unsigned NUM_W   = COLOR_W + ITER_W;

  localparam int unsigned CFG_ADDR_W = 6;
  localparam int unsigned CFG_DATA_W = 64;

  // Nearest Q4.28 values of the mapping constants.
  localparam logic [31:0] Q_ONE_5   = 32'd402653184;
  localparam logic [31:0] Q_TWO     = 32'd536870912;
  localparam logic [31:0] Q_TWO_2   = 32'd590558003;
  localparam logic [31:0] Q_THREE   = 32'd805306368;
  localparam logic [31:0] Q_THREE_4 = 32'd912680550;
  localparam logic [31:0] Q_FOUR    = 32'd1073741824;

  // Escape threshold: |z|^2 > 4 with both squares in Q8.56.
  localparam logic [63:0] ESC_LIMIT = 64'd1 << 58;

  localparam logic [31:0] ZOOM_RESET     = 32'h1000_0000;
  localparam logic [12:0] MAX_ITER_RESET = 13'd100;
  localparam logic [47:0] COLOR_RESET    = 48'hFFFF_FF00_0000;

  typedef enum logic [2:0] {
    REG_JULIA_MODE = 3'd0,
    REG_ZOOM       = 3'd1,
    REG_PAN_REAL   = 3'd2,
    REG_PAN_IMAG   = 3'd3,
    REG_JULIA_REAL = 3'd4,
    REG_JULIA_IMAG = 3'd5,
    REG_MAX_ITER   = 3'd6,
    REG_COLOR_PAIR = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic               julia_mode;
    logic [31:0]        zoom;
    logic signed [31:0] pan_real;
    logic signed [31:0] pan_imag;
    logic signed [31:0] julia_real;
    logic signed [31:0] julia_imag;
    logic [12:0]        max_iter;
    logic [47:0]        color_pair;
  } cfg_t;

  // One mapped pixel waiting for the iteration engine.
  typedef struct packed {
    logic signed [31:0] zr;
    logic signed [31:0] zi;
    logic signed [31:0] cr;
    logic signed [31:0] ci;
    logic [21:0]        offset;
  } item_t;

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -48'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = $signed(v[31:0]);
    end
    return r;
  endfunction

  // Arithmetic shift right that rounds toward zero, as a signed division does.
  function automatic logic signed [64:0] shr_tz(input logic signed [64:0] v,
                                               input int unsigned sh);
    logic signed [64:0] bias;
    logic signed [64:0] r;
    bias = (65'sd1 <<< sh) - 65'sd1;
    if (v[64]) begin
      r = (v + bias) >>> sh;
    end else begin
      r = v >>> sh;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/efp_queue.sv =====
// ----------------------------------------------------------------------------
// efp_queue: small FIFO between the mapping front end and the iteration engine
// Flop-based storage with a first-word read port, so either side can stall
// without holding up the other.
// ----------------------------------------------------------------------------
module efp_queue #(
  parameter int unsigned DATA_W = 150,
  parameter int unsigned DEPTH  = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic [DATA_W-1:0] pop_data_o,
  output logic              empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  assign full_o     = (cnt_q == CNT_W'(DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hw/rtl/efp_front.sv =====
// ----------------------------------------------------------------------------
// efp_front: pixel intake and coordinate mapping
// Maps a pixel onto the complex plane, applies zoom and pan, picks the
// constant c by mode and pushes the start values into the queue.
// ----------------------------------------------------------------------------
module efp_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  efp_pkg::cfg_t        cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [9:0]           pixel_x_i,
  input  logic [9:0]           pixel_y_i,
  output logic                 push_o,
  output efp_pkg::item_t       push_item_o,
  input  logic                 full_i
);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_MAP  = 4'b0010,
    F_ZOOM = 4'b0100,
    F_PUSH = 4'b1000
  } front_state_e;

  front_state_e state_q, state_d;

  logic [9:0]         x_q, y_q;
  logic signed [31:0] mr_q, mr_d, mi_q, mi_d;
  logic signed [64:0] prod_r_q, prod_r_d, prod_i_q, prod_i_d;

  logic [31:0]        scale_x, scale_y, off_x, off_y;
  logic [41:0]        xm, ym, xq, yq;
  logic signed [47:0] mr_wide, mi_wide;
  logic signed [32:0] zoom_s;
  logic signed [64:0] zr_sh, zi_sh;
  logic signed [47:0] zr_wide, zi_wide;
  logic signed [31:0] zr, zi;
  logic [31:0]        offs_wide;

  // Plane spans differ by mode; only the constants change.
  always_comb begin
    scale_x = cfg_i.julia_mode ? efp_pkg::Q_FOUR : efp_pkg::Q_THREE_4;
    off_x   = cfg_i.julia_mode ? efp_pkg::Q_TWO  : efp_pkg::Q_TWO_2;
    scale_y = cfg_i.julia_mode ? efp_pkg::Q_FOUR : efp_pkg::Q_THREE;
    off_y   = cfg_i.julia_mode ? efp_pkg::Q_TWO  : efp_pkg::Q_ONE_5;
    xm      = 42'(scale_x) * 42'(x_q);
    ym      = 42'(scale_y) * 42'(y_q);
    xq      = xm / 42'(efp_pkg::IMG_WIDTH);
    yq      = ym / 42'(efp_pkg::IMG_HEIGHT);
    mr_wide = $signed({6'd0, xq}) - $signed({16'd0, off_x});
    mi_wide = $signed({16'd0, off_y}) - $signed({6'd0, yq});
    mr_d    = efp_pkg::sat32(mr_wide);
    mi_d    = efp_pkg::sat32(mi_wide);
  end

  always_comb begin
    zoom_s   = $signed({1'b0, cfg_i.zoom});
    prod_r_d = mr_q * zoom_s;
    prod_i_d = mi_q * zoom_s;
  end

  always_comb begin
    zr_sh   = efp_pkg::shr_tz(prod_r_q, efp_pkg::FRAC);
    zi_sh   = efp_pkg::shr_tz(prod_i_q, efp_pkg::FRAC);
    zr_wide = $signed(zr_sh[47:0]) + $signed({{16{cfg_i.pan_real[31]}}, cfg_i.pan_real});
    zi_wide = $signed(zi_sh[47:0]) + $signed({{16{cfg_i.pan_imag[31]}}, cfg_i.pan_imag});
    zr      = efp_pkg::sat32(zr_wide);
    zi      = efp_pkg::sat32(zi_wide);
    offs_wide = 32'(y_q) * 32'(efp_pkg::LINE_BYTES)
              + 32'(x_q) * 32'(efp_pkg::BYTES_PER_PIXEL);

    push_item_o.zr     = zr;
    push_item_o.zi     = zi;
    push_item_o.cr     = cfg_i.julia_mode ? cfg_i.julia_real : zr;
    push_item_o.ci     = cfg_i.julia_mode ? cfg_i.julia_imag : zi;
    push_item_o.offset = offs_wide[efp_pkg::OFFS_W-1:0];
  end

  assign in_stall_o = (state_q != F_IDLE);
  assign push_o     = (state_q == F_PUSH) && !full_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE: begin
        if (in_valid_i) state_d = F_MAP;
      end
      F_MAP:  state_d = F_ZOOM;
      F_ZOOM: state_d = F_PUSH;
      F_PUSH: begin
        if (!full_i) state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && in_valid_i) begin
      x_q <= pixel_x_i;
      y_q <= pixel_y_i;
    end
    if (state_q == F_MAP) begin
      mr_q <= mr_d;
      mi_q <= mi_d;
    end
    if (state_q == F_ZOOM) begin
      prod_r_q <= prod_r_d;
      prod_i_q <= prod_i_d;
    end
  end

endmodule

// ===== hw/rtl/efp_back.sv =====
// ----------------------------------------------------------------------------
// efp_back: iteration engine and color interpolation
// Runs z = z^2 + c with one multiply step and one update step per iteration,
// then on escape divides the interpolated color by max_iter one bit per cycle.
// ----------------------------------------------------------------------------
module efp_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  efp_pkg::cfg_t        cfg_i,
  input  logic                 empty_i,
  input  efp_pkg::item_t       pop_item_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [23:0]          pixel_color_o,
  output logic [21:0]          pixel_offset_o
);

  localparam int unsigned NUM_W = efp_pkg::NUM_W;
  localparam int unsigned BIT_W = $clog2(NUM_W);

  typedef enum logic [5:0] {
    B_IDLE = 6'b000001,
    B_MUL  = 6'b000010,
    B_ADD  = 6'b000100,
    B_NUM  = 6'b001000,
    B_DIV  = 6'b010000,
    B_DONE = 6'b100000
  } back_state_e;

  back_state_e state_q, state_d;

  logic signed [31:0] zr_q, zi_q, cr_q, ci_q;
  logic [21:0]        offset_q;
  logic [12:0]        m_q, count_q, esc_q;
  logic signed [63:0] rr_q, ii_q, ri_q;
  logic [NUM_W-1:0]   div_q, div_d;
  logic [12:0]        rem_q, rem_d;
  logic [BIT_W-1:0]   bit_q;
  logic [23:0]        color_q;

  logic               out_valid_q;
  logic [23:0]        out_color_q;
  logic [21:0]        out_offset_q;
  logic               slot_free;

  logic [63:0]        mag;
  logic               escaped;
  logic signed [64:0] diff, ri_ext, re_sh, im_sh;
  logic signed [47:0] nr_wide, ni_wide;
  logic signed [31:0] nr, ni;
  logic [23:0]        c1, c2;
  logic [12:0]        m_minus;
  logic [NUM_W-1:0]   num;
  logic [13:0]        rem_sh;
  logic               ge;

  assign c1 = cfg_i.color_pair[47:24];
  assign c2 = cfg_i.color_pair[23:0];

  // Squares of the new z come from the multiply step of the next pass, so the
  // escape test for update i is made one pass later.
  always_comb begin
    mag     = {1'b0, rr_q[62:0]} + {1'b0, ii_q[62:0]};
    escaped = (count_q != '0) && (mag > efp_pkg::ESC_LIMIT);
    diff    = $signed({rr_q[63], rr_q}) - $signed({ii_q[63], ii_q});
    ri_ext  = $signed({ri_q[63], ri_q});
    re_sh   = efp_pkg::shr_tz(diff, efp_pkg::FRAC);
    im_sh   = efp_pkg::shr_tz(ri_ext, efp_pkg::FRAC - 1);
    nr_wide = $signed(re_sh[47:0]) + $signed({{16{cr_q[31]}}, cr_q});
    ni_wide = $signed(im_sh[47:0]) + $signed({{16{ci_q[31]}}, ci_q});
    nr      = efp_pkg::sat32(nr_wide);
    ni      = efp_pkg::sat32(ni_wide);
  end

  // The numerator c2*(m-i) + c1*i never goes negative because i < m.
  always_comb begin
    m_minus = m_q - esc_q;
    num     = NUM_W'(c2) * NUM_W'(m_minus) + NUM_W'(c1) * NUM_W'(esc_q);
    rem_sh  = {rem_q, div_q[NUM_W-1]};
    ge      = (rem_sh >= {1'b0, m_q});
    rem_d   = ge ? 13'(rem_sh - {1'b0, m_q}) : rem_sh[12:0];
    div_d   = {div_q[NUM_W-2:0], ge};
  end

  assign slot_free = !out_valid_q || !out_stall_i;
  assign pop_o     = (state_q == B_IDLE) && !empty_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: begin
        if (!empty_i) state_d = B_MUL;
      end
      B_MUL: state_d = B_ADD;
      B_ADD: begin
        if (escaped) begin
          state_d = B_NUM;
        end else if (count_q == m_q) begin
          state_d = B_DONE;
        end else begin
          state_d = B_MUL;
        end
      end
      B_NUM: state_d = B_DIV;
      B_DIV: begin
        if (bit_q == BIT_W'(NUM_W - 1)) state_d = B_DONE;
      end
      B_DONE: begin
        if (slot_free) state_d = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == B_DONE && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          zr_q     <= pop_item_i.zr;
          zi_q     <= pop_item_i.zi;
          cr_q     <= pop_item_i.cr;
          ci_q     <= pop_item_i.ci;
          offset_q <= pop_item_i.offset;
          m_q      <= cfg_i.max_iter;
          count_q  <= '0;
        end
      end
      B_MUL: begin
        rr_q <= zr_q * zr_q;
        ii_q <= zi_q * zi_q;
        ri_q <= zr_q * zi_q;
      end
      B_ADD: begin
        if (escaped) begin
          esc_q <= count_q - 1'b1;
        end else if (count_q == m_q) begin
          color_q <= c1;
        end else begin
          zr_q    <= nr;
          zi_q    <= ni;
          count_q <= count_q + 1'b1;
        end
      end
      B_NUM: begin
        div_q <= num;
        rem_q <= '0;
        bit_q <= '0;
      end
      B_DIV: begin
        div_q <= div_d;
        rem_q <= rem_d;
        bit_q <= bit_q + 1'b1;
        if (bit_q == BIT_W'(NUM_W - 1)) begin
          color_q <= div_d[23:0];
        end
      end
      B_DONE: begin
        if (slot_free) begin
          out_color_q  <= color_q;
          out_offset_q <= offset_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_color_o  = out_color_q;
  assign pixel_offset_o = out_offset_q;

  ap_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_DIV) |-> (rem_q < m_q))
    else $error("divider remainder reached the divisor");

  ap_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_MUL || state_q == B_ADD) |-> (count_q <= m_q))
    else $error("iteration count ran past max_iter");

endmodule

// ===== hw/rtl/escape_time_fractal_pixel.sv =====
// ----------------------------------------------------------------------------
// escape_time_fractal_pixel: Mandelbrot / Julia escape-time pixel engine
// Maps each pixel onto the complex plane in Q4.28, iterates z = z^2 + c and
// returns the interpolated color and the frame buffer byte offset.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------
//  pixel   | in        | in_valid_i / in_stall_o| pixel_x_i, pixel_y_i
//  result  | out       | out_valid_o/out_stall_i| pixel_color_o, pixel_offset_o
//  config  | in        | APB psel/penable/pready| paddr, pwdata, prdata (64 bit)
//
// The iteration engine runs a multiply step and an update step per iteration.
// A pixel that escapes then passes through the numerator step and the
// bit-serial color divider. The front end maps the next pixel while the
// engine works, and up to QUEUE_DEPTH mapped pixels wait between them. Reset
// clears all control state and loads the register reset values.
// ----------------------------------------------------------------------------
module escape_time_fractal_pixel #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [9:0]  pixel_x_i,
  input  logic [9:0]  pixel_y_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [23:0] pixel_color_o,
  output logic [21:0] pixel_offset_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int unsigned ITEM_W = $bits(efp_pkg::item_t);

  efp_pkg::cfg_t      cfg_q;
  efp_pkg::reg_idx_e  reg_idx;
  logic               cfg_wr;

  logic               q_push, q_pop, q_full, q_empty;
  efp_pkg::item_t     push_item, pop_item;
  logic [ITEM_W-1:0]  pop_data;

  assign pready  = 1'b1;
  assign reg_idx = efp_pkg::reg_idx_e'(paddr[5:3]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.julia_mode <= 1'b0;
      cfg_q.zoom       <= efp_pkg::ZOOM_RESET;
      cfg_q.pan_real   <= '0;
      cfg_q.pan_imag   <= '0;
      cfg_q.julia_real <= '0;
      cfg_q.julia_imag <= '0;
      cfg_q.max_iter   <= efp_pkg::MAX_ITER_RESET;
      cfg_q.color_pair <= efp_pkg::COLOR_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        efp_pkg::REG_JULIA_MODE: cfg_q.julia_mode <= pwdata[0];
        efp_pkg::REG_ZOOM:       cfg_q.zoom       <= pwdata[31:0];
        efp_pkg::REG_PAN_REAL:   cfg_q.pan_real   <= $signed(pwdata[31:0]);
        efp_pkg::REG_PAN_IMAG:   cfg_q.pan_imag   <= $signed(pwdata[31:0]);
        efp_pkg::REG_JULIA_REAL: cfg_q.julia_real <= $signed(pwdata[31:0]);
        efp_pkg::REG_JULIA_IMAG: cfg_q.julia_imag <= $signed(pwdata[31:0]);
        efp_pkg::REG_MAX_ITER:   cfg_q.max_iter   <= pwdata[12:0];
        efp_pkg::REG_COLOR_PAIR: cfg_q.color_pair <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      efp_pkg::REG_JULIA_MODE: prdata = {63'd0, cfg_q.julia_mode};
      efp_pkg::REG_ZOOM:       prdata = {32'd0, cfg_q.zoom};
      efp_pkg::REG_PAN_REAL:   prdata = {32'd0, cfg_q.pan_real};
      efp_pkg::REG_PAN_IMAG:   prdata = {32'd0, cfg_q.pan_imag};
      efp_pkg::REG_JULIA_REAL: prdata = {32'd0, cfg_q.julia_real};
      efp_pkg::REG_JULIA_IMAG: prdata = {32'd0, cfg_q.julia_imag};
      efp_pkg::REG_MAX_ITER:   prdata = {51'd0, cfg_q.max_iter};
      efp_pkg::REG_COLOR_PAIR: prdata = {16'd0, cfg_q.color_pair};
      default:                 prdata = '0;
    endcase
  end

  efp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pixel_x_i   (pixel_x_i),
    .pixel_y_i   (pixel_y_i),
    .push_o      (q_push),
    .push_item_o (push_item),
    .full_i      (q_full)
  );

  efp_queue #(
    .DATA_W (ITEM_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (push_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (pop_data),
    .empty_o     (q_empty)
  );

  assign pop_item = efp_pkg::item_t'(pop_data);

  efp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .empty_i        (q_empty),
    .pop_item_i     (pop_item),
    .pop_o          (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pixel_color_o  (pixel_color_o),
    .pixel_offset_o (pixel_offset_o)
  );

  ap_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("front end pushed into a full queue");

  ap_pop_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("engine popped an empty queue");

endmodule

// ===== tb/efp_pixel_checker.sv =====
// ----------------------------------------------------------------------------
// efp_pixel_checker: result predictor and scoreboard for the fractal pixel engine
// Follows the configuration writes on the register port and works out the color
// and frame buffer offset of every pixel accepted on the input channel. Each
// result transfer is compared with the oldest outstanding pixel.
// ----------------------------------------------------------------------------
module efp_pixel_checker
  import efp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [9:0]  pixel_x_i,
  input  logic [9:0]  pixel_y_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [23:0] pixel_color_i,
  input  logic [21:0] pixel_offset_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [5:0]  paddr_i,
  input  logic [63:0] pwdata_i,
  input  logic        pready_i,
  output int          outstanding_o,
  output int          fail_count_o
);

  localparam longint Q_UNIT    = 64'sd268435456;
  localparam longint Q_HALF    = 64'sd134217728;
  localparam longint S32_MAX   = 64'sd2147483647;
  localparam longint S32_MIN   = -64'sd2147483648;
  localparam longint WIDTH_L   = longint'(IMG_WIDTH);
  localparam longint HEIGHT_L  = longint'(IMG_HEIGHT);
  localparam longint LINE_L    = longint'(LINE_BYTES);
  localparam longint PIXBYTE_L = longint'(BYTES_PER_PIXEL);

  typedef struct packed {
    logic [9:0]  px;
    logic [9:0]  py;
    logic [23:0] color;
    logic [21:0] offset;
  } pixel_result_t;

  logic               cfg_julia;
  logic [31:0]        cfg_zoom;
  logic signed [31:0] cfg_pan_re;
  logic signed [31:0] cfg_pan_im;
  logic signed [31:0] cfg_c_re;
  logic signed [31:0] cfg_c_im;
  logic [12:0]        cfg_max_iter;
  logic [47:0]        cfg_colors;

  pixel_result_t expected_pixels[$];
  int            mismatches = 0;
  int            waiting    = 0;

  assign outstanding_o = waiting;
  assign fail_count_o  = mismatches;

  function automatic longint clamp_s32(input longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  function automatic longint zoom_and_pan(input longint mapped,
                                          input logic signed [31:0] pan);
    longint scaled;
    scaled = (clamp_s32(mapped) * longint'(cfg_zoom)) / Q_UNIT;
    return clamp_s32(scaled + longint'(pan));
  endfunction

  function automatic longint unsigned square_mag(input longint v);
    longint unsigned a;
    a = (v < 0) ? -v : v;
    return a * a;
  endfunction

  function automatic pixel_result_t predict_pixel(input logic [9:0] px,
                                                  input logic [9:0] py);
    pixel_result_t r;
    longint xs, ys, mr, mi, zr, zi, cr, ci, nr, ni, m, d, num;
    logic [23:0] c1, c2;
    int it;
    xs = longint'(px);
    ys = longint'(py);
    c1 = cfg_colors[47:24];
    c2 = cfg_colors[23:0];
    r.px = px;
    r.py = py;
    r.color = c1;
    if (!cfg_julia) begin
      mr = (longint'(Q_THREE_4) * xs) / WIDTH_L - longint'(Q_TWO_2);
      mi = longint'(Q_ONE_5) - (longint'(Q_THREE) * ys) / HEIGHT_L;
    end else begin
      mr = (longint'(Q_FOUR) * xs) / WIDTH_L - longint'(Q_TWO);
      mi = longint'(Q_TWO) - (longint'(Q_FOUR) * ys) / HEIGHT_L;
    end
    zr = zoom_and_pan(mr, cfg_pan_re);
    zi = zoom_and_pan(mi, cfg_pan_im);
    if (!cfg_julia) begin
      cr = zr;
      ci = zi;
    end else begin
      cr = longint'(cfg_c_re);
      ci = longint'(cfg_c_im);
    end
    for (it = 0; it < int'(cfg_max_iter); it++) begin
      nr = clamp_s32((zr * zr - zi * zi) / Q_UNIT + cr);
      ni = clamp_s32((zr * zi) / Q_HALF + ci);
      zr = nr;
      zi = ni;
      if (square_mag(zr) + square_mag(zi) > ESC_LIMIT) begin
        // Interpolate from color_2 toward color_1 by the escape iteration.
        m = longint'(cfg_max_iter);
        d = longint'(c1) - longint'(c2);
        num = longint'(c2) * m + d * longint'(it);
        r.color = 24'(num / m);
        break;
      end
    end
    r.offset = 22'(ys * LINE_L + xs * PIXBYTE_L);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_result_t exp_px;
    if (!rst_ni) begin
      expected_pixels.delete();
      waiting      = 0;
      cfg_julia    = 1'b0;
      cfg_zoom     = ZOOM_RESET;
      cfg_pan_re   = '0;
      cfg_pan_im   = '0;
      cfg_c_re     = '0;
      cfg_c_im     = '0;
      cfg_max_iter = MAX_ITER_RESET;
      cfg_colors   = COLOR_RESET;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_pixels.size() == 0) begin
          $error("result transfer with no pixel outstanding: color %06h, offset %06h",
                 pixel_color_i, pixel_offset_i);
          mismatches++;
        end else begin
          exp_px = expected_pixels.pop_front();
          if (pixel_color_i !== exp_px.color) begin
            $error("pixel_color mismatch at pixel (%0d,%0d): expected %06h, actual %06h",
                   exp_px.px, exp_px.py, exp_px.color, pixel_color_i);
            mismatches++;
          end
          if (pixel_offset_i !== exp_px.offset) begin
            $error("pixel_offset mismatch at pixel (%0d,%0d): expected %06h, actual %06h",
                   exp_px.px, exp_px.py, exp_px.offset, pixel_offset_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_pixels.push_back(predict_pixel(pixel_x_i, pixel_y_i));
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[5:3]))
          REG_JULIA_MODE: cfg_julia    = pwdata_i[0];
          REG_ZOOM:       cfg_zoom     = pwdata_i[31:0];
          REG_PAN_REAL:   cfg_pan_re   = pwdata_i[31:0];
          REG_PAN_IMAG:   cfg_pan_im   = pwdata_i[31:0];
          REG_JULIA_REAL: cfg_c_re     = pwdata_i[31:0];
          REG_JULIA_IMAG: cfg_c_im     = pwdata_i[31:0];
          REG_MAX_ITER:   cfg_max_iter = pwdata_i[12:0];
          REG_COLOR_PAIR: cfg_colors   = pwdata_i[47:0];
          default: ;
        endcase
      end
      waiting = expected_pixels.size();
    end
  end

endmodule

// ===== tb/tb_escape_time_fractal_pixel.sv =====
// ----------------------------------------------------------------------------
// tb_escape_time_fractal_pixel: regression bench for the fractal pixel engine
// Drives directed corner pixels and register extremes, random register settings
// with random pixels under several idling patterns on both channels, and a final
// deep Julia run. A separate checker predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module tb_escape_time_fractal_pixel;
  import efp_pkg::*;

  localparam int CLK_PERIOD       = 12;
  localparam int RESET_CYCLES     = 8;
  localparam int RANDOM_PHASES    = 16;
  localparam int PIXELS_PER_PHASE = 103;
  localparam int DEEP_PIXELS      = 10;
  localparam int SETTLE_CYCLES    = 100;
  localparam int RUN_LIMIT_CYCLES = 2_500_000;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [9:0]  pixel_x_i   = '0;
  logic [9:0]  pixel_y_i   = '0;
  logic        out_stall_i = 1'b0;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [5:0]  paddr       = '0;
  logic [63:0] pwdata      = '0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [23:0] pixel_color_o;
  logic [21:0] pixel_offset_o;
  logic [63:0] prdata;
  logic        pready;

  int sender_idle_pct = 0;
  int stall_pct       = 0;
  int pixels_in_flight;
  int fail_count;

  escape_time_fractal_pixel i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .pixel_x_i     (pixel_x_i),
    .pixel_y_i     (pixel_y_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_color_o (pixel_color_o),
    .pixel_offset_o(pixel_offset_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  efp_pixel_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .pixel_x_i     (pixel_x_i),
    .pixel_y_i     (pixel_y_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_color_i (pixel_color_o),
    .pixel_offset_i(pixel_offset_o),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .pready_i      (pready),
    .outstanding_o (pixels_in_flight),
    .fail_count_o  (fail_count)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  task automatic set_idling(input int pattern);
    case (pattern)
      0: begin sender_idle_pct = 0;  stall_pct = 0;  end
      1: begin sender_idle_pct = 62; stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  stall_pct = 62; end
      default: begin sender_idle_pct = 16; stall_pct = 16; end
    endcase
  endtask

  // Called and returns at a falling edge with nothing scheduled in that step.
  task automatic write_reg(input reg_idx_e idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_pixel(input logic [9:0] px, input logic [9:0] py);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_x_i  <= px;
    pixel_y_i  <= py;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Registers may only change once every outstanding pixel has come back.
  task automatic drain_pixels();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pixels_in_flight != 0) @(negedge clk_i);
  endtask

  function automatic logic [9:0] random_coord();
    case ($urandom_range(19))
      0: return 10'd0;
      1: return 10'd1023;
      default: return 10'($urandom_range(1023));
    endcase
  endfunction

  // Random Q4.28 pattern within plus or minus span.
  function automatic logic [31:0] near_q(input int unsigned span);
    return 32'($urandom_range(2 * span) - span);
  endfunction

  task automatic random_setting();
    logic [31:0] zoom_val;
    logic [12:0] iter_val;
    case ($urandom_range(9))
      0: zoom_val = 32'h0000_0000;
      1: zoom_val = 32'hFFFF_FFFF;
      2, 3: zoom_val = $urandom;
      default: zoom_val = $urandom_range(32'h4000_0000, 32'h0200_0000);
    endcase
    case ($urandom_range(7))
      0: iter_val = 13'd1;
      1: iter_val = 13'd100;
      default: iter_val = 13'($urandom_range(64, 2));
    endcase
    write_reg(REG_JULIA_MODE, 64'($urandom_range(1)));
    write_reg(REG_ZOOM, 64'(zoom_val));
    write_reg(REG_PAN_REAL, 64'(($urandom_range(4) == 0) ? $urandom : near_q(32'h2000_0000)));
    write_reg(REG_PAN_IMAG, 64'(($urandom_range(4) == 0) ? $urandom : near_q(32'h2000_0000)));
    write_reg(REG_JULIA_REAL, 64'(($urandom_range(4) == 0) ? $urandom : near_q(32'h1000_0000)));
    write_reg(REG_JULIA_IMAG, 64'(($urandom_range(4) == 0) ? $urandom : near_q(32'h1000_0000)));
    write_reg(REG_MAX_ITER, 64'(iter_val));
    write_reg(REG_COLOR_PAIR, {16'h0, 16'($urandom), 32'($urandom)});
  endtask

  initial begin
    int phase;
    int n;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);
    set_idling(0);

    // Reset settings: image corners, a point deep inside the set, a few others.
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd512, 10'd512);
    send_pixel(10'd640, 10'd384);
    send_pixel(10'd341, 10'd682);
    drain_pixels();

    // An iteration limit of zero never iterates and always returns color_1.
    write_reg(REG_MAX_ITER, 64'd0);
    send_pixel(10'd100, 10'd200);
    send_pixel(10'd1023, 10'd511);
    drain_pixels();

    // Limits above 4096 with a Julia constant of zero: the origin never escapes.
    write_reg(REG_JULIA_MODE, 64'd1);
    write_reg(REG_JULIA_REAL, 64'd0);
    write_reg(REG_JULIA_IMAG, 64'd0);
    write_reg(REG_COLOR_PAIR, 64'h0000_1234_56AB_CDEF);
    write_reg(REG_MAX_ITER, 64'd8191);
    send_pixel(10'd512, 10'd512);
    send_pixel(10'd0, 10'd0);
    drain_pixels();
    write_reg(REG_MAX_ITER, 64'd4097);
    send_pixel(10'd600, 10'd450);
    drain_pixels();

    // Largest zoom with the pan at both extremes saturates the corner start points.
    write_reg(REG_JULIA_MODE, 64'd0);
    write_reg(REG_MAX_ITER, 64'd100);
    write_reg(REG_ZOOM, 64'hFFFF_FFFF);
    write_reg(REG_PAN_REAL, 64'h7FFF_FFFF);
    write_reg(REG_PAN_IMAG, 64'h8000_0000);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd512, 10'd512);
    drain_pixels();
    write_reg(REG_PAN_REAL, 64'h8000_0000);
    write_reg(REG_PAN_IMAG, 64'h7FFF_FFFF);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd0, 10'd1023);
    drain_pixels();

    // Zero zoom in Julia mode with the constant at its extremes.
    write_reg(REG_JULIA_MODE, 64'd1);
    write_reg(REG_ZOOM, 64'd0);
    write_reg(REG_JULIA_REAL, 64'h7FFF_FFFF);
    write_reg(REG_JULIA_IMAG, 64'h8000_0000);
    write_reg(REG_COLOR_PAIR, 64'h0000_FFFF_FFFF_FFFF);
    send_pixel(10'd5, 10'd5);
    drain_pixels();
    write_reg(REG_JULIA_REAL, 64'h8000_0000);
    write_reg(REG_JULIA_IMAG, 64'h7FFF_FFFF);
    write_reg(REG_COLOR_PAIR, 64'd0);
    send_pixel(10'd1022, 10'd3);
    drain_pixels();

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      random_setting();
      set_idling(phase % 4);
      for (n = 0; n < PIXELS_PER_PHASE; n++) begin
        send_pixel(random_coord(), random_coord());
      end
      drain_pixels();
    end

    // Largest regular limit: a small Julia window around the origin never escapes.
    set_idling(3);
    write_reg(REG_JULIA_MODE, 64'd1);
    write_reg(REG_ZOOM, 64'h0400_0000);
    write_reg(REG_PAN_REAL, 64'd0);
    write_reg(REG_PAN_IMAG, 64'd0);
    write_reg(REG_JULIA_REAL, 64'd0);
    write_reg(REG_JULIA_IMAG, 64'd0);
    write_reg(REG_MAX_ITER, 64'd4096);
    for (n = 0; n < DEEP_PIXELS; n++) begin
      send_pixel(random_coord(), random_coord());
    end
    drain_pixels();

    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("escape_time_fractal_pixel regression: pass");
    end else begin
      $display("escape_time_fractal_pixel regression: fail");
    end
    $finish;
  end

  initial begin
    repeat (RUN_LIMIT_CYCLES) @(posedge clk_i);
    $display("escape_time_fractal_pixel regression: fail");
    $finish;
  end

endmodule

// ===== escape_time_fractal_pixel.f =====
hw/rtl/efp_pkg.sv
hw/rtl/efp_queue.sv
hw/rtl/efp_front.sv
hw/rtl/efp_back.sv
hw/rtl/escape_time_fractal_pixel.sv
tb/efp_pixel_checker.sv
tb/tb_escape_time_fractal_pixel.sv
